// File: design/smpg_pkg.sv
// Shared types, constants and rounding helpers for the sphere mesh point generator.
`default_nettype none
package smpg_pkg;

   localparam int DEF_MAX_SLICES       = 254;
   localparam int DEF_SINE_TABLE_DEPTH = 1024;

   // Quarter turn of the 16-bit phase and pi/2 in Q2.30.
   localparam logic [15:0] QUARTER_TURN = 16'h4000;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [7:0]  SLICES_MIN    = 8'd4;
   localparam logic [7:0]  RESET_SLICES  = 8'd20;
   localparam logic [15:0] RESET_RADIUS  = 16'd256;
   localparam logic [14:0] RESET_STEP    = 15'd3277;

   typedef enum logic [1:0] {
      CSR_SLICE_COUNT   = 2'd0,
      CSR_SPHERE_RADIUS = 2'd1,
      CSR_PHASE_STEP    = 2'd2
   } csr_index_type;

   // Per-point bookkeeping that travels alongside the trigonometry.
   typedef struct packed {
      logic [14:0] vertex_index;
      logic        point_valid;
      logic        quad_valid;
   } point_type;

   // Shift right by 15 with rounding half away from zero.
   function automatic logic signed [17:0] round_q15(input logic signed [32:0] v);
      logic signed [33:0] ve;
      logic [33:0]        mag;
      logic [33:0]        sum;
      logic signed [18:0] r19;
      ve  = 34'(v);
      mag = ve[33] ? 34'(-ve) : 34'(ve);
      sum = (mag + 34'd16384) >> 15;
      r19 = $signed({1'b0, sum[17:0]});
      return 18'(ve[33] ? -r19 : r19);
   endfunction

endpackage
`default_nettype wire

// File: design/smpg_front.sv
// Input stage: grid range checks, vertex number and the four lookup phases.
`default_nettype none
module smpg_front #(
   parameter int MAX_SLICES = smpg_pkg::DEF_MAX_SLICES
) (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire logic [6:0]          parallel_index,
   input  wire logic [7:0]          slice_index,
   input  wire logic [7:0]          slice_count,
   input  wire logic [14:0]         phase_step,
   output logic [15:0]              phase_si,
   output logic [15:0]              phase_ci,
   output logic [15:0]              phase_sj,
   output logic [15:0]              phase_cj,
   output smpg_pkg::point_type      point
);
   import smpg_pkg::*;

   localparam logic [7:0] SLICES_MAX = 8'(MAX_SLICES);

   logic [7:0]  slices;
   logic [6:0]  rings;
   logic [21:0] prod_i;
   logic [22:0] prod_j;
   logic [15:0] vert_sum;
   logic [15:0] pa, pb;
   logic [15:0] phase_si_ff, phase_ci_ff, phase_sj_ff, phase_cj_ff;
   logic [15:0] phase_si_in, phase_ci_in, phase_sj_in, phase_cj_in;
   point_type   point_ff, point_in;

   always_comb begin
      if (slice_count < SLICES_MIN) begin
         slices = SLICES_MIN;
      end else if (slice_count > SLICES_MAX) begin
         slices = SLICES_MAX;
      end else begin
         slices = slice_count;
      end
      rings = slices[7:1];

      prod_i = 22'(parallel_index) * 22'(phase_step);
      prod_j = 23'(slice_index) * 23'(phase_step);
      pa     = prod_i[15:0];
      pb     = prod_j[15:0];

      phase_si_in = pa;
      phase_ci_in = pa + QUARTER_TURN;
      phase_sj_in = pb;
      phase_cj_in = pb + QUARTER_TURN;

      vert_sum = 16'(parallel_index) * (16'(slices) + 16'd1) + 16'(slice_index);
      point_in.vertex_index = vert_sum[14:0];
      point_in.point_valid  = ({1'b0, parallel_index} <= {1'b0, rings})
                              && (slice_index <= slices);
      point_in.quad_valid   = (parallel_index < rings) && (slice_index < slices);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         phase_si_ff <= phase_si_in;
         phase_ci_ff <= phase_ci_in;
         phase_sj_ff <= phase_sj_in;
         phase_cj_ff <= phase_cj_in;
         point_ff    <= point_in;
      end
   end

   assign phase_si = phase_si_ff;
   assign phase_ci = phase_ci_ff;
   assign phase_sj = phase_sj_ff;
   assign phase_cj = phase_cj_ff;
   assign point    = point_ff;

endmodule
`default_nettype wire

// File: design/smpg_sine_rom.sv
// Quarter-wave sine lookup: address stage, registered ROM read and sign fix-up.
`default_nettype none
module smpg_sine_rom #(
   parameter int SINE_TABLE_DEPTH = smpg_pkg::DEF_SINE_TABLE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               addr_enable,
   input  wire logic               read_enable,
   input  wire logic [15:0]        phase,
   output logic signed [15:0]      sine
);
   import smpg_pkg::*;

   localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PW = 14 + AW;

   typedef logic [14:0] rom_type [0:SINE_TABLE_DEPTH];

   // Taylor series of sin in Q2.30, rounded to Q1.15, evaluated at elaboration.
   function automatic rom_type build_rom();
      rom_type         tab;
      longint unsigned x, t, q;
      longint          s;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
         t = x;
         s = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            t = ((((t * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               s = s - longint'(t);
            end else begin
               s = s + longint'(t);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         if (s > 64'sd1073741824) begin
            s = 64'sd1073741824;
         end
         q = (64'(s) * 64'd32767 + 64'd536870912) >> 30;
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         tab[k] = q[14:0];
      end
      return tab;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [PW-1:0] scaled;
   logic [AW-1:0] index;
   logic [AW-1:0] addr_ff, addr_in;
   logic          neg_ff, neg_in;
   logic          neg_rd_ff;
   logic [14:0]   data_ff;

   always_comb begin
      scaled  = PW'(phase[13:0]) * PW'(SINE_TABLE_DEPTH);
      index   = scaled[PW-1:14];
      // Odd quadrants walk the table backwards, the lower half-turn is negative.
      addr_in = phase[14] ? AW'(SINE_TABLE_DEPTH) - index : index;
      neg_in  = phase[15];
   end

   always_ff @(posedge clock) begin
      if (addr_enable) begin
         addr_ff <= addr_in;
         neg_ff  <= neg_in;
      end
      if (read_enable) begin
         data_ff   <= SINE_ROM[addr_ff];
         neg_rd_ff <= neg_ff;
      end
   end

   assign sine = neg_rd_ff ? -$signed({1'b0, data_ff}) : $signed({1'b0, data_ff});

endmodule
`default_nettype wire

// File: design/smpg_product.sv
// Back end: normal products, radius scaling, rounding and the output register.
`default_nettype none
module smpg_product (
   input  wire logic                 clock,
   input  wire logic [3:0]           enable,
   input  wire logic signed [15:0]   sin_i,
   input  wire logic signed [15:0]   cos_i,
   input  wire logic signed [15:0]   sin_j,
   input  wire logic signed [15:0]   cos_j,
   input  wire smpg_pkg::point_type  point,
   input  wire logic [15:0]          sphere_radius,
   output logic signed [16:0]        pos_x,
   output logic signed [16:0]        pos_y,
   output logic signed [16:0]        pos_z,
   output logic signed [15:0]        normal_x,
   output logic signed [15:0]        normal_y,
   output logic signed [15:0]        normal_z,
   output smpg_pkg::point_type       point_out
);
   import smpg_pkg::*;

   // Products of sin_i with sin_j and with cos_j.
   logic signed [31:0] prod_x_ff, prod_z_ff;
   logic signed [15:0] ny_d_ff;
   point_type          point_d_ff;
   // Rounded normals.
   logic signed [15:0] nx_e_ff, ny_e_ff, nz_e_ff;
   point_type          point_e_ff;
   // Radius products.
   logic signed [32:0] px_f_ff, py_f_ff, pz_f_ff;
   logic signed [15:0] nx_f_ff, ny_f_ff, nz_f_ff;
   point_type          point_f_ff;
   // Output register.
   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [16:0] pos_x_in, pos_y_in, pos_z_in;
   logic signed [15:0] normal_x_ff, normal_y_ff, normal_z_ff;
   point_type          point_g_ff;
   logic signed [17:0] rx, ry, rz;
   logic signed [17:0] nx_round, nz_round;
   logic signed [16:0] radius_s;

   always_comb begin
      nx_round = round_q15(33'(prod_x_ff));
      nz_round = round_q15(33'(prod_z_ff));
      radius_s = $signed({1'b0, sphere_radius});
      rx       = round_q15(px_f_ff);
      ry       = round_q15(py_f_ff);
      rz       = round_q15(pz_f_ff);
      pos_x_in = 17'(rx);
      pos_y_in = 17'(ry);
      pos_z_in = 17'(rz);
   end

   always_ff @(posedge clock) begin
      if (enable[0]) begin
         prod_x_ff  <= sin_i * sin_j;
         prod_z_ff  <= sin_i * cos_j;
         ny_d_ff    <= cos_i;
         point_d_ff <= point;
      end
      if (enable[1]) begin
         nx_e_ff    <= 16'(nx_round);
         nz_e_ff    <= 16'(nz_round);
         ny_e_ff    <= ny_d_ff;
         point_e_ff <= point_d_ff;
      end
      if (enable[2]) begin
         px_f_ff    <= radius_s * nx_e_ff;
         py_f_ff    <= radius_s * ny_e_ff;
         pz_f_ff    <= radius_s * nz_e_ff;
         nx_f_ff    <= nx_e_ff;
         ny_f_ff    <= ny_e_ff;
         nz_f_ff    <= nz_e_ff;
         point_f_ff <= point_e_ff;
      end
      if (enable[3]) begin
         // A point off the grid reports zero in every field.
         if (point_f_ff.point_valid) begin
            pos_x_ff    <= pos_x_in;
            pos_y_ff    <= pos_y_in;
            pos_z_ff    <= pos_z_in;
            normal_x_ff <= nx_f_ff;
            normal_y_ff <= ny_f_ff;
            normal_z_ff <= nz_f_ff;
            point_g_ff  <= point_f_ff;
         end else begin
            pos_x_ff    <= '0;
            pos_y_ff    <= '0;
            pos_z_ff    <= '0;
            normal_x_ff <= '0;
            normal_y_ff <= '0;
            normal_z_ff <= '0;
            point_g_ff  <= '0;
         end
      end
   end

   assign pos_x     = pos_x_ff;
   assign pos_y     = pos_y_ff;
   assign pos_z     = pos_z_ff;
   assign normal_x  = normal_x_ff;
   assign normal_y  = normal_y_ff;
   assign normal_z  = normal_z_ff;
   assign point_out = point_g_ff;

endmodule
`default_nettype wire

// File: design/sphere_mesh_point_generator.sv
// Top level of the UV sphere grid point generator: registers, flow control, datapath.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   parallel_index, slice_index
//   rsp_      out        rsp_valid / rsp_stall   pos_xyz, normal_xyz, vertex_index, flags
//   csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// One point is taken per cycle while req_stall is low. Its result is presented once it
// has passed through every stage, and transfers in a cycle in which rsp_stall is low.
// The stages are: phases, ROM address, ROM read, sine products, normal rounding,
// radius products, output register. Each stage has its own valid bit and holds while
// the stage after it is full and held, so bubbles close up under a stalled output.
// Reset clears the valid bits and loads the default register values.
`default_nettype none
module sphere_mesh_point_generator #(
   parameter int MAX_SLICES       = smpg_pkg::DEF_MAX_SLICES,
   parameter int SINE_TABLE_DEPTH = smpg_pkg::DEF_SINE_TABLE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [6:0]         req_parallel_index,
   input  wire logic [7:0]         req_slice_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [16:0]      rsp_pos_x,
   output logic signed [16:0]      rsp_pos_y,
   output logic signed [16:0]      rsp_pos_z,
   output logic signed [15:0]      rsp_normal_x,
   output logic signed [15:0]      rsp_normal_y,
   output logic signed [15:0]      rsp_normal_z,
   output logic [14:0]             rsp_vertex_index,
   output logic                    rsp_point_valid,
   output logic                    rsp_quad_valid,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);
   import smpg_pkg::*;

   localparam int STAGES = 7;

   logic [7:0]         slice_count_ff;
   logic [15:0]        sphere_radius_ff;
   logic [14:0]        phase_step_ff;
   logic [STAGES-1:0]  valid_ff, valid_in;
   logic [STAGES-1:0]  advance;
   logic [15:0]        phase_si, phase_ci, phase_sj, phase_cj;
   logic signed [15:0] sin_i, cos_i, sin_j, cos_j;
   point_type          point_a, point_b_ff, point_c_ff, point_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_count_ff   <= RESET_SLICES;
         sphere_radius_ff <= RESET_RADIUS;
         phase_step_ff    <= RESET_STEP;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SLICE_COUNT:   slice_count_ff   <= csr_data[7:0];
            CSR_SPHERE_RADIUS: sphere_radius_ff <= csr_data;
            CSR_PHASE_STEP:    phase_step_ff    <= csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   // A stage takes new data when it is empty or its contents move on.
   always_comb begin
      advance[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
      valid_in[0] = advance[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = advance[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance[1]) begin
         point_b_ff <= point_a;
      end
      if (advance[2]) begin
         point_c_ff <= point_b_ff;
      end
   end

   assign req_stall = !advance[0];
   assign rsp_valid = valid_ff[STAGES-1];

   smpg_front #(
      .MAX_SLICES (MAX_SLICES)
   ) u_front (
      .clock          (clock),
      .enable         (advance[0]),
      .parallel_index (req_parallel_index),
      .slice_index    (req_slice_index),
      .slice_count    (slice_count_ff),
      .phase_step     (phase_step_ff),
      .phase_si       (phase_si),
      .phase_ci       (phase_ci),
      .phase_sj       (phase_sj),
      .phase_cj       (phase_cj),
      .point          (point_a)
   );

   smpg_sine_rom #(.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)) u_rom_si (
      .clock (clock), .addr_enable (advance[1]), .read_enable (advance[2]),
      .phase (phase_si), .sine (sin_i)
   );

   smpg_sine_rom #(.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)) u_rom_ci (
      .clock (clock), .addr_enable (advance[1]), .read_enable (advance[2]),
      .phase (phase_ci), .sine (cos_i)
   );

   smpg_sine_rom #(.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)) u_rom_sj (
      .clock (clock), .addr_enable (advance[1]), .read_enable (advance[2]),
      .phase (phase_sj), .sine (sin_j)
   );

   smpg_sine_rom #(.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)) u_rom_cj (
      .clock (clock), .addr_enable (advance[1]), .read_enable (advance[2]),
      .phase (phase_cj), .sine (cos_j)
   );

   smpg_product u_product (
      .clock         (clock),
      .enable        (advance[6:3]),
      .sin_i         (sin_i),
      .cos_i         (cos_i),
      .sin_j         (sin_j),
      .cos_j         (cos_j),
      .point         (point_c_ff),
      .sphere_radius (sphere_radius_ff),
      .pos_x         (rsp_pos_x),
      .pos_y         (rsp_pos_y),
      .pos_z         (rsp_pos_z),
      .normal_x      (rsp_normal_x),
      .normal_y      (rsp_normal_y),
      .normal_z      (rsp_normal_z),
      .point_out     (point_out)
   );

   assign rsp_vertex_index = point_out.vertex_index;
   assign rsp_point_valid  = point_out.point_valid;
   assign rsp_quad_valid   = point_out.quad_valid;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UV sphere grid point generator.
module tb_top;
   import smpg_pkg::*;

   localparam int CLOCK_PERIOD_NS  = 12;
   localparam int RESET_CYCLES     = 10;
   localparam int PIPE_LATENCY     = 7;
   localparam int END_IDLE_CYCLES  = 4 * PIPE_LATENCY;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int MAX_REPORTS      = 40;
   localparam int NUM_PHASES       = 20;
   localparam int SLICE_LIMIT      = 254;
   localparam int ROM_DEPTH        = 1024;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   typedef enum int {
      RX_FREE,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_mode_type;

   typedef struct packed {
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [14:0]        vertex_index;
      logic               point_valid;
      logic               quad_valid;
   } mesh_point_type;

   typedef struct packed {
      logic [6:0]     ring;
      logic [7:0]     slice;
      logic           typed;
      mesh_point_type result;
   } point_row_type;

   localparam mesh_point_type OFF_GRID = '0;
   localparam mesh_point_type ORIGIN_AT_RESET = '{
      pos_x: 17'sd0, pos_y: 17'sd256, pos_z: 17'sd0,
      normal_x: 16'sd0, normal_y: 16'sd32767, normal_z: 16'sd0,
      vertex_index: 15'd0, point_valid: 1'b1, quad_valid: 1'b1
   };

   // Walked with the reset settings: 20 slices, 10 rings. Rows with typed clear
   // are checked against the predictor and their result column is unused.
   localparam int NUM_DIRECTED = 20;
   localparam point_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{7'd0,   8'd0,   1'b1, ORIGIN_AT_RESET},
      '{7'd0,   8'd20,  1'b0, OFF_GRID},
      '{7'd10,  8'd0,   1'b0, OFF_GRID},
      '{7'd10,  8'd20,  1'b0, OFF_GRID},
      '{7'd9,   8'd19,  1'b0, OFF_GRID},
      '{7'd1,   8'd1,   1'b0, OFF_GRID},
      '{7'd5,   8'd5,   1'b0, OFF_GRID},
      '{7'd5,   8'd10,  1'b0, OFF_GRID},
      '{7'd5,   8'd15,  1'b0, OFF_GRID},
      '{7'd3,   8'd7,   1'b0, OFF_GRID},
      '{7'd10,  8'd10,  1'b0, OFF_GRID},
      '{7'd11,  8'd0,   1'b1, OFF_GRID},
      '{7'd0,   8'd21,  1'b1, OFF_GRID},
      '{7'd11,  8'd21,  1'b1, OFF_GRID},
      '{7'd127, 8'd255, 1'b1, OFF_GRID},
      '{7'd127, 8'd0,   1'b1, OFF_GRID},
      '{7'd0,   8'd255, 1'b1, OFF_GRID},
      '{7'd85,  8'd170, 1'b1, OFF_GRID},
      '{7'd42,  8'd85,  1'b1, OFF_GRID},
      '{7'd7,   8'd13,  1'b0, OFF_GRID}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [6:0]         req_parallel_index;
   logic [7:0]         req_slice_index;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [16:0] rsp_pos_x;
   logic signed [16:0] rsp_pos_y;
   logic signed [16:0] rsp_pos_z;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic [14:0]        rsp_vertex_index;
   logic               rsp_point_valid;
   logic               rsp_quad_valid;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;

   // Copy of the register file as the block should see it.
   logic [7:0]  cfg_slices = RESET_SLICES;
   logic [15:0] cfg_radius = RESET_RADIUS;
   logic [14:0] cfg_step   = RESET_STEP;

   int unsigned    quarter_wave [0:ROM_DEPTH];
   mesh_point_type predicted_points [$];
   int             error_count    = 0;
   int             idle_cycles    = 0;
   int             burst_left     = 1;
   bit             gaps_on        = 1'b1;
   int             hold_requests  = 0;

   sphere_mesh_point_generator #(
      .MAX_SLICES       (SLICE_LIMIT),
      .SINE_TABLE_DEPTH (ROM_DEPTH)
   ) i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD_NS / 2) clock = ~clock;
   end

   // Quarter-wave sine entry k in Q1.15, by a truncated Taylor series in Q2.30.
   function automatic int quarter_sine_entry(int k);
      longint unsigned x;
      longint unsigned t;
      longint unsigned q;
      longint          s;
      x = (PI_HALF_Q30 * longint'(unsigned'(k))) / ROM_DEPTH;
      t = x;
      s = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         t = ((((t * x) >> 30) * x) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) s -= longint'(t);
         else s += longint'(t);
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      q = (longint'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (q > 64'd32767) q = 64'd32767;
      return int'(q);
   endfunction

   function automatic longint phase_sine(logic [15:0] phase);
      int     idx;
      longint v;
      idx = (int'(phase[13:0]) * ROM_DEPTH) >> 14;
      v = phase[14] ? longint'(quarter_wave[ROM_DEPTH - idx]) : longint'(quarter_wave[idx]);
      return phase[15] ? -v : v;
   endfunction

   function automatic longint round_away(longint v, int sh);
      longint half;
      half = 64'sd1 <<< (sh - 1);
      if (v >= 0) return (v + half) >>> sh;
      return -((-v + half) >>> sh);
   endfunction

   function automatic int effective_slices();
      int s;
      s = int'(cfg_slices);
      if (s < int'(SLICES_MIN)) s = int'(SLICES_MIN);
      if (s > SLICE_LIMIT) s = SLICE_LIMIT;
      return s;
   endfunction

   function automatic mesh_point_type predict_point(logic [6:0] ring, logic [7:0] slice);
      int             s_eff;
      int             p_eff;
      logic [15:0]    pa;
      logic [15:0]    pb;
      longint         si;
      longint         ci;
      longint         sj;
      longint         cj;
      longint         nx;
      longint         ny;
      longint         nz;
      longint         r;
      mesh_point_type res;
      res = '0;
      s_eff = effective_slices();
      p_eff = s_eff / 2;
      if (int'(ring) > p_eff || int'(slice) > s_eff) return res;
      pa = 16'(int'(ring) * int'(cfg_step));
      pb = 16'(int'(slice) * int'(cfg_step));
      si = phase_sine(pa);
      ci = phase_sine(pa + QUARTER_TURN);
      sj = phase_sine(pb);
      cj = phase_sine(pb + QUARTER_TURN);
      nx = round_away(si * sj, 15);
      ny = ci;
      nz = round_away(si * cj, 15);
      r = longint'(cfg_radius);
      res.pos_x        = 17'(round_away(r * nx, 15));
      res.pos_y        = 17'(round_away(r * ny, 15));
      res.pos_z        = 17'(round_away(r * nz, 15));
      res.normal_x     = 16'(nx);
      res.normal_y     = 16'(ny);
      res.normal_z     = 16'(nz);
      res.vertex_index = 15'(int'(ring) * (s_eff + 1) + int'(slice));
      res.point_valid  = 1'b1;
      res.quad_valid   = (int'(ring) < p_eff) && (int'(slice) < s_eff);
      return res;
   endfunction

   task automatic send_point(input logic [6:0] ring, input logic [7:0] slice,
                             input bit typed, input mesh_point_type typed_result,
                             input bit keep_valid);
      req_valid          <= 1'b1;
      req_parallel_index <= ring;
      req_slice_index    <= slice;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_points.push_back(typed ? typed_result : predict_point(ring, slice));
      if (!keep_valid) req_valid <= 1'b0;
   endtask

   // Bursts of transfers, with idle gaps between them while gaps_on is set; valid stays high inside a burst.
   task automatic offer_point(input logic [6:0] ring, input logic [7:0] slice,
                              input bit typed, input mesh_point_type typed_result,
                              input bit last);
      bit keep;
      burst_left--;
      keep = !last && (burst_left > 0 || !gaps_on);
      send_point(ring, slice, typed, typed_result, keep);
      if (!keep && !last) repeat ($urandom_range(1, 6)) @(posedge clock);
      if (burst_left <= 0) burst_left = $urandom_range(1, 24);
   endtask

   task automatic wait_for_results();
      while (predicted_points.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_SLICE_COUNT:   cfg_slices = data[7:0];
         CSR_SPHERE_RADIUS: cfg_radius = data;
         CSR_PHASE_STEP:    cfg_step   = data[14:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // The unused upper bits of the slice count and phase step words are filled with noise.
   task automatic configure(input logic [7:0] slices, input logic [15:0] radius,
                            input logic [14:0] step, input bit poke_unmapped);
      write_csr(CSR_SLICE_COUNT, {8'($urandom), slices});
      write_csr(CSR_SPHERE_RADIUS, radius);
      if (poke_unmapped) write_csr(CSR_UNMAPPED, 16'($urandom));
      write_csr(CSR_PHASE_STEP, {1'($urandom), step});
   endtask

   task automatic check_field(input string name, input logic signed [31:0] want_v,
                              input logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         if (error_count < MAX_REPORTS)
            $display("%0t rsp %s: expected %0d, actual %0d", $time, name, want_v, got_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_checker
      mesh_point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_points.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("%0t rsp: unexpected transfer, vertex_index %0d",
                        $time, rsp_vertex_index);
            error_count++;
         end else begin
            want = predicted_points.pop_front();
            check_field("pos_x", want.pos_x, rsp_pos_x);
            check_field("pos_y", want.pos_y, rsp_pos_y);
            check_field("pos_z", want.pos_z, rsp_pos_z);
            check_field("normal_x", want.normal_x, rsp_normal_x);
            check_field("normal_y", want.normal_y, rsp_normal_y);
            check_field("normal_z", want.normal_z, rsp_normal_z);
            check_field("vertex_index", want.vertex_index, rsp_vertex_index);
            check_field("point_valid", want.point_valid, rsp_point_valid);
            check_field("quad_valid", want.quad_valid, rsp_quad_valid);
         end
      end
   end

   always @(posedge clock) begin : transfer_watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Output back-pressure: changing patterns, plus long holds on request.
   initial begin : rsp_backpressure
      rx_mode_type mode;
      int          mode_left;
      int          period;
      int          tick;
      int          holds_served;
      bit          stall;
      mode_left    = 0;
      period       = 2;
      tick         = 0;
      holds_served = 0;
      mode         = RX_FREE;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
               period    = $urandom_range(2, 9);
            end
            mode_left--;
            tick++;
            case (mode)
               RX_FREE:     stall = 1'b0;
               RX_LIGHT:    stall = ($urandom_range(0, 99) < 30);
               RX_HEAVY:    stall = ($urandom_range(0, 99) < 70);
               default:     stall = (tick % period) == 0;
            endcase
            rsp_stall <= stall;
         end
      end
   end

   initial begin : stimulus
      int          items;
      int          s_eff;
      int          p_eff;
      bit          pause_here;
      logic [6:0]  ring;
      logic [7:0]  slice;
      logic [7:0]  slices;
      logic [14:0] step;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_parallel_index <= '0;
      req_slice_index    <= '0;
      csr_valid          <= 1'b0;
      csr_index          <= '0;
      csr_data           <= '0;
      for (int k = 0; k <= ROM_DEPTH; k++) quarter_wave[k] = quarter_sine_entry(k);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_DIRECTED; r++)
         offer_point(DIRECTED_ROWS[r].ring, DIRECTED_ROWS[r].slice, DIRECTED_ROWS[r].typed,
                     DIRECTED_ROWS[r].result, r == NUM_DIRECTED - 1);
      wait_for_results();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: configure(8'd4, 16'hFFFF, 15'd16384, 1'b1);
            1: configure(8'd254, 16'd0, 15'd1, 1'b0);
            2: configure(8'd0, RESET_RADIUS, 15'd32767, 1'b1);
            3: configure(8'd255, 16'hFFFF, 15'd258, 1'b0);
            4: configure(8'd3, 16'($urandom), 15'd21845, 1'b0);
            5: configure(8'd7, 16'($urandom), 15'd9362, 1'b1);
            default: begin
               slices = 8'($urandom);
               cfg_slices = slices;
               if ($urandom_range(0, 1) == 1)
                  step = 15'(65536 / effective_slices());
               else
                  step = 15'($urandom_range(1, 16384));
               configure(slices, 16'($urandom), step, $urandom_range(0, 3) == 0);
            end
         endcase
         gaps_on = $urandom_range(0, 3) != 0;
         s_eff = effective_slices();
         p_eff = s_eff / 2;
         items = $urandom_range(60, 95);
         for (int k = 0; k < items; k++) begin
            // Mostly points on the grid; the rest is unconstrained noise.
            if ($urandom_range(0, 99) < 85) begin
               ring  = 7'($urandom_range(0, p_eff));
               slice = 8'($urandom_range(0, s_eff));
            end else begin
               ring  = 7'($urandom);
               slice = 8'($urandom);
            end
            if ((phase == 2 || phase == 12) && k == 20) hold_requests++;
            pause_here = (phase == 3 || phase == 9) && k == items / 2;
            offer_point(ring, slice, 1'b0, OFF_GRID, pause_here || k == items - 1);
            if (pause_here) wait_for_results();
         end
         wait_for_results();
      end

      repeat (END_IDLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
